[hw/rtl/hsc_pkg.sv]
// shared types, widths, codes and bit-mapping functions of the hamming sec codec
// no dependencies; used by every module of the codec
`default_nettype none

package hsc_pkg;

    localparam int CODE_W = 63;
    localparam int DATA_W = 57;
    localparam int SYN_W = 6;
    localparam int LEN_W = 6;
    localparam int PAR_W = 3;
    localparam int MAX_DATA_BITS = 57;
    localparam logic [LEN_W-1:0] RESET_DATA_LENGTH = 6'd4;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] k;
        logic [PAR_W-1:0] r;
        logic [LEN_W-1:0] n;
    } t_dims;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] word;
    } t_word;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] word;
        logic [SYN_W-1:0]  syn;
    } t_syn;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] data;
        logic [SYN_W-1:0]  syn;
        logic              err;
    } t_result;

    function automatic t_dims f_dims(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] k;
        logic [PAR_W-1:0] r;
        t_dims            d;
        k = len;
        if (k == '0) begin
            k = LEN_W'(1);
        end
        if (k > LEN_W'(MAX_DATA_BITS)) begin
            k = LEN_W'(MAX_DATA_BITS);
        end
        r = PAR_W'(SYN_W);
        for (int rr = SYN_W; rr >= 1; rr--) begin
            if ((32'd1 << rr) >= (32'(k) + 32'(rr) + 32'd1)) begin
                r = PAR_W'(rr);
            end
        end
        d.k = k;
        d.r = r;
        d.n = k + LEN_W'(r);
        return d;
    endfunction

    function automatic logic f_is_pow2(input int v);
        return (v != 0) && ((v & (v - 1)) == 0);
    endfunction

    // data bits go to the positions that are not powers of two, in order
    function automatic logic [CODE_W-1:0] f_scatter(input logic [DATA_W-1:0] data);
        logic [CODE_W-1:0] code;
        int                d;
        code = '0;
        d = 0;
        for (int j = 1; j <= CODE_W; j++) begin
            if (!f_is_pow2(j)) begin
                if (d < DATA_W) begin
                    code[j-1] = data[d];
                end
                d++;
            end
        end
        return code;
    endfunction

    function automatic logic [DATA_W-1:0] f_gather(input logic [CODE_W-1:0] code);
        logic [DATA_W-1:0] data;
        int                d;
        data = '0;
        d = 0;
        for (int j = 1; j <= CODE_W; j++) begin
            if (!f_is_pow2(j)) begin
                if (d < DATA_W) begin
                    data[d] = code[j-1];
                end
                d++;
            end
        end
        return data;
    endfunction

    // parity bit i covers every position whose index has bit i set
    function automatic logic [SYN_W-1:0] f_syndrome(input logic [CODE_W-1:0] word);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int i = 0; i < SYN_W; i++) begin
            for (int j = 1; j <= CODE_W; j++) begin
                if (((j >> i) & 1) == 1) begin
                    s[i] = s[i] ^ word[j-1];
                end
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hsc_place.sv]
// first pipeline stage: masks the request and places it in codeword positions
// depends on hsc_pkg
`default_nettype none

module hsc_place (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hsc_pkg::t_dims              i_dims,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_kind,
    input  wire logic [hsc_pkg::DATA_W-1:0]  i_data_word,
    input  wire logic [hsc_pkg::CODE_W-1:0]  i_code_in,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output hsc_pkg::t_word                   o_word
);

    logic                          r_valid;
    hsc_pkg::t_word                r_word;
    hsc_pkg::t_word                n_word;
    logic [hsc_pkg::DATA_W-1:0]    data_mask;
    logic [hsc_pkg::CODE_W-1:0]    code_mask;

    always_comb begin
        for (int i = 0; i < hsc_pkg::DATA_W; i++) begin
            data_mask[i] = (i < int'(i_dims.k));
        end
        for (int i = 0; i < hsc_pkg::CODE_W; i++) begin
            code_mask[i] = (i < int'(i_dims.n));
        end
    end

    always_comb begin
        n_word.kind = i_kind;
        if (i_kind == hsc_pkg::KIND_ENCODE) begin
            n_word.word = hsc_pkg::f_scatter(i_data_word & data_mask);
        end else begin
            n_word.word = i_code_in & code_mask;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

[hw/rtl/hsc_syndrome.sv]
// second pipeline stage: xor trees that form the syndrome of the placed word
// depends on hsc_pkg
`default_nettype none

module hsc_syndrome (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsc_pkg::t_word i_word,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hsc_pkg::t_syn       o_syn
);

    logic          r_valid;
    hsc_pkg::t_syn r_syn;
    hsc_pkg::t_syn n_syn;

    always_comb begin
        n_syn.kind = i_word.kind;
        n_syn.word = i_word.word;
        n_syn.syn  = hsc_pkg::f_syndrome(i_word.word);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_syn <= n_syn;
        end
    end

    assign o_valid = r_valid;
    assign o_syn   = r_syn;

endmodule

`default_nettype wire

[hw/rtl/hsc_correct.sv]
// third pipeline stage: inserts parity on encode, corrects and extracts data on decode
// depends on hsc_pkg; holds the output register of the codec
`default_nettype none

module hsc_correct (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hsc_pkg::t_dims i_dims,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsc_pkg::t_syn  i_syn,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hsc_pkg::t_result    o_result
);

    logic                       r_valid;
    hsc_pkg::t_result           r_result;
    hsc_pkg::t_result           n_result;
    logic [hsc_pkg::CODE_W-1:0] code;
    logic [hsc_pkg::CODE_W-1:0] flip;

    always_comb begin
        code = i_syn.word;
        flip = '0;
        n_result = '0;
        if (i_syn.kind == hsc_pkg::KIND_ENCODE) begin
            // parity bit i sits at position 2^i
            for (int i = 0; i < hsc_pkg::SYN_W; i++) begin
                code[(1 << i) - 1] = i_syn.syn[i];
            end
            n_result.code = code;
        end else begin
            if (i_syn.syn != '0 && i_syn.syn <= i_dims.n) begin
                flip = hsc_pkg::CODE_W'(1) << (i_syn.syn - hsc_pkg::SYN_W'(1));
            end
            n_result.code = code ^ flip;
            n_result.data = hsc_pkg::f_gather(code ^ flip);
            n_result.syn  = i_syn.syn;
            n_result.err  = (i_syn.syn > i_dims.n);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hw/rtl/hamming_sec_codec_core.sv]
// top level of the hamming single-error-correcting codec
// depends on hsc_pkg, hsc_place, hsc_syndrome and hsc_correct
`default_nettype none

// Hamming SEC encoder/decoder for k = 1..57 data bits, n = k + r codeword bits.
// A request with kind 0 encodes i_data_word (bits at or above k ignored); kind 1
// decodes i_code_in (bits at or above n ignored), flips the bit named by a syndrome
// in 1..n, flags a nonzero syndrome above n and returns the data bits. Codeword
// bit i-1 holds position i; parity bits sit at the power-of-two positions.
// The datapath is a three-stage pipeline (placement, syndrome xor trees,
// correction and extraction), so a request can be accepted every clock while the
// output side is ready; each request passes the placement, syndrome and correction registers in order.
// The last stage doubles as the output register; back pressure stalls the stages
// in place without loss. The data length register (zero reads as one, values
// above 57 as 57) is written through its own valid/ready port, always ready, and
// must only be changed while no request is in flight. Reset value is 4 (n = 7).

module hamming_sec_codec_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [hsc_pkg::LEN_W-1:0]   i_cfg_data_length,
    // request channel
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_kind,
    input  wire logic [hsc_pkg::DATA_W-1:0]  i_data_word,
    input  wire logic [hsc_pkg::CODE_W-1:0]  i_code_in,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [hsc_pkg::CODE_W-1:0]       o_code_out,
    output logic [hsc_pkg::DATA_W-1:0]       o_data_out,
    output logic [hsc_pkg::SYN_W-1:0]        o_syndrome,
    output logic                             o_error_out_of_range,
    output logic [hsc_pkg::LEN_W-1:0]        o_code_length,
    output logic [hsc_pkg::PAR_W-1:0]        o_parity_count
);

    // code dimensions are derived once at the write, not per request
    hsc_pkg::t_dims   r_dims;

    // inter-stage signals
    logic             place_valid;
    logic             syn_ready;
    hsc_pkg::t_word   place_word;
    logic             syn_valid;
    logic             corr_ready;
    hsc_pkg::t_syn    syn_word;
    hsc_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= hsc_pkg::f_dims(hsc_pkg::RESET_DATA_LENGTH);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dims <= hsc_pkg::f_dims(i_cfg_data_length);
        end
    end

    // stage 1: mask and place data or received word
    hsc_place u_place (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (r_dims),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_data_word (i_data_word),
        .i_code_in   (i_code_in),
        .o_valid     (place_valid),
        .i_ready     (syn_ready),
        .o_word      (place_word)
    );

    // stage 2: syndrome over all positions, the upper ones are already zero
    hsc_syndrome u_syndrome (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (place_valid),
        .o_ready (syn_ready),
        .i_word  (place_word),
        .o_valid (syn_valid),
        .i_ready (corr_ready),
        .o_syn   (syn_word)
    );

    // stage 3: parity insertion or single-bit correction, then the output register
    hsc_correct u_correct (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (r_dims),
        .i_valid  (syn_valid),
        .o_ready  (corr_ready),
        .i_syn    (syn_word),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_code_out           = result.code;
    assign o_data_out           = result.data;
    assign o_syndrome           = result.syn;
    assign o_error_out_of_range = result.err;
    // the user must keep dimensions stable while requests are in flight; the block does not enforce it
    assign o_code_length        = r_dims.n;
    assign o_parity_count       = r_dims.r;

endmodule

`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for hamming_sec_codec_core: encode and decode requests
// checked against a bit-level hamming sec predictor kept in a small scoreboard class
// depends on hsc_pkg and the rtl of hamming_sec_codec_core
`default_nettype none

module testbench;
    import hsc_pkg::*;

    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_PHASES = 12;
    localparam int REQUESTS_PER_PHASE = 78;

    // one result word as the block reports it
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] data;
        logic [SYN_W-1:0]  syn;
        logic              err;
        logic [LEN_W-1:0]  code_len;
        logic [PAR_W-1:0]  par_cnt;
    } codec_word_t;

    // hamming predictor plus the queue of results still owed by the block
    class hamming_scoreboard;
        logic [LEN_W-1:0] data_length;
        codec_word_t      owed_words[$];
        int unsigned      noted;
        int unsigned      errors;

        function new();
            data_length = RESET_DATA_LENGTH;
            noted = 0;
            errors = 0;
        endfunction

        static function int parity_bits(int k);
            int r;
            r = 1;
            while (r < 7 && (1 << r) < k + r + 1) r++;
            return r;
        endfunction

        // zero acts as one, oversize lengths shrink until n fits in 63 bits
        function void code_size(output int k, output int r, output int n);
            k = int'(data_length);
            if (k == 0) k = 1;
            r = parity_bits(k);
            while (k > 1 && k + r > CODE_W) begin
                k--;
                r = parity_bits(k);
            end
            n = k + r;
        endfunction

        static function bit parity_position(int j);
            return (j & (j - 1)) == 0;
        endfunction

        static function logic [SYN_W-1:0] syndrome_over(logic [CODE_W-1:0] word, int n, int r);
            logic [SYN_W-1:0] s;
            s = '0;
            for (int i = 0; i < r; i++) begin
                for (int j = 1; j <= n; j++) begin
                    if (((j >> i) & 1) == 1) s[i] = s[i] ^ word[j-1];
                end
            end
            return s;
        endfunction

        function codec_word_t codec_result(logic kind, logic [DATA_W-1:0] data_word,
                                           logic [CODE_W-1:0] code_in);
            codec_word_t      res;
            logic [SYN_W-1:0] s;
            int               k, r, n, d;
            code_size(k, r, n);
            res = '0;
            res.code_len = LEN_W'(n);
            res.par_cnt = PAR_W'(r);
            if (kind == KIND_ENCODE) begin
                d = 0;
                for (int j = 1; j <= n; j++) begin
                    if (!parity_position(j)) begin
                        res.code[j-1] = data_word[d];
                        d++;
                    end
                end
                s = syndrome_over(res.code, n, r);
                for (int i = 0; i < r; i++) res.code[(1 << i) - 1] = s[i];
            end else begin
                for (int j = 1; j <= n; j++) res.code[j-1] = code_in[j-1];
                s = syndrome_over(res.code, n, r);
                if (s != 0 && s <= n) begin
                    res.code[s-1] = ~res.code[s-1];
                end else if (s > n) begin
                    res.err = 1'b1;
                end
                res.syn = s;
                d = 0;
                for (int j = 1; j <= n; j++) begin
                    if (!parity_position(j)) begin
                        res.data[d] = res.code[j-1];
                        d++;
                    end
                end
            end
            return res;
        endfunction

        function void note_request(logic kind, logic [DATA_W-1:0] data_word,
                                   logic [CODE_W-1:0] code_in);
            owed_words.push_back(codec_result(kind, data_word, code_in));
            noted++;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(codec_word_t got);
            codec_word_t want;
            if (owed_words.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, expected none actual code %h",
                         $time, got.code);
                return;
            end
            want = owed_words.pop_front();
            compare_field("code_out", 64'(want.code), 64'(got.code));
            compare_field("data_out", 64'(want.data), 64'(got.data));
            compare_field("syndrome", 64'(want.syn), 64'(got.syn));
            compare_field("error_out_of_range", 64'(want.err), 64'(got.err));
            compare_field("code_length", 64'(want.code_len), 64'(got.code_len));
            compare_field("parity_count", 64'(want.par_cnt), 64'(got.par_cnt));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [LEN_W-1:0]  i_cfg_data_length = RESET_DATA_LENGTH;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_kind = KIND_ENCODE;
    logic [DATA_W-1:0] i_data_word = '0;
    logic [CODE_W-1:0] i_code_in = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [CODE_W-1:0] o_code_out;
    logic [DATA_W-1:0] o_data_out;
    logic [SYN_W-1:0]  o_syndrome;
    logic              o_error_out_of_range;
    logic [LEN_W-1:0]  o_code_length;
    logic [PAR_W-1:0]  o_parity_count;

    hamming_scoreboard sb = new();
    int unsigned       sent = 0;
    int unsigned       quiet_cycles = 0;
    // both sides stop idling while this is set
    bit                steady = 1'b0;

    hamming_sec_codec_core u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data_length    (i_cfg_data_length),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_kind               (i_kind),
        .i_data_word          (i_data_word),
        .i_code_in            (i_code_in),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_code_out           (o_code_out),
        .o_data_out           (o_data_out),
        .o_syndrome           (o_syndrome),
        .o_error_out_of_range (o_error_out_of_range),
        .o_code_length        (o_code_length),
        .o_parity_count       (o_parity_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // requests are noted before results are checked, both from pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_request(i_kind, i_data_word, i_code_in);
        end
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(codec_word_t'{o_code_out, o_data_out, o_syndrome,
                                          o_error_out_of_range, o_code_length,
                                          o_parity_count});
        end
    end

    // result side back pressure, about a quarter of the cycles
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 24);
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // random idle cycles first, then hold the request until it is taken
    task automatic send_request(input logic kind, input logic [DATA_W-1:0] data_word,
                                input logic [CODE_W-1:0] code_in);
        while (!steady && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            i_kind <= 1'($urandom_range(1));
            i_data_word <= DATA_W'(rand_word());
            i_code_in <= CODE_W'(rand_word());
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_data_word <= data_word;
        i_code_in <= code_in;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
    endtask

    // only written once every owed result has come back
    task automatic write_length(input logic [LEN_W-1:0] len);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.noted != sent || sb.owed_words.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data_length <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.data_length = len;
    endtask

    // codewords with zero, one or two flipped bits, nearly as many encodes, some noise
    task automatic random_request();
        int                k, r, n, pick;
        logic [CODE_W-1:0] word, beyond;
        sb.code_size(k, r, n);
        pick = $urandom_range(99);
        beyond = CODE_W'(rand_word());
        if (n < CODE_W) begin
            beyond = beyond & ~((CODE_W'(1) << n) - CODE_W'(1));
        end else begin
            beyond = '0;
        end
        if (pick < 40) begin
            send_request(KIND_ENCODE, DATA_W'(rand_word()), CODE_W'(rand_word()));
        end else if (pick < 85) begin
            word = sb.codec_result(KIND_ENCODE, DATA_W'(rand_word()), '0).code;
            repeat ($urandom_range(2)) begin
                word[$urandom_range(n - 1)] ^= 1'b1;
            end
            if ($urandom_range(1) == 1) word = word | beyond;
            send_request(KIND_DECODE, DATA_W'(rand_word()), word);
        end else begin
            send_request(KIND_DECODE, DATA_W'(rand_word()), CODE_W'(rand_word()));
        end
    endtask

    initial begin
        logic [LEN_W-1:0] phase_lengths [RANDOM_PHASES];
        logic [CODE_W-1:0] word;

        phase_lengths = '{6'd1, 6'd57, 6'd2, 6'd3, 6'd0, 6'd58, 6'd63, 6'd11, 6'd26,
                          6'd4, 6'd4, 6'd4};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length 4: n = 7, r = 3
        send_request(KIND_ENCODE, '0, CODE_W'(rand_word()));
        send_request(KIND_ENCODE, '1, '0);
        send_request(KIND_DECODE, DATA_W'(rand_word()), '0);
        send_request(KIND_DECODE, '0, '1);
        // error on the first parity bit
        send_request(KIND_DECODE, '0, CODE_W'(1));
        // error on the last position of the code
        word = sb.codec_result(KIND_ENCODE, DATA_W'(4'hb), '0).code;
        send_request(KIND_DECODE, '0, word ^ CODE_W'(7'h40));
        // nothing but bits beyond the code
        send_request(KIND_DECODE, '0, ~CODE_W'(7'h7f));
        // data bits beyond k set
        send_request(KIND_ENCODE, ~DATA_W'(4'h5), '0);

        // longest code: k = 57, n = 63
        write_length(6'd57);
        send_request(KIND_ENCODE, '1, '0);
        send_request(KIND_ENCODE, '0, '1);
        send_request(KIND_DECODE, '0, '1);
        send_request(KIND_DECODE, '0, CODE_W'(1) << 62);
        word = sb.codec_result(KIND_ENCODE, DATA_W'(rand_word()), '0).code;
        send_request(KIND_DECODE, '0, word ^ (CODE_W'(1) << 31));

        // k = 5, n = 9: double errors whose syndrome lands past the code
        write_length(6'd5);
        send_request(KIND_DECODE, '0, CODE_W'(9'h084));
        send_request(KIND_DECODE, '0, CODE_W'(9'h120));
        send_request(KIND_ENCODE, '1, '0);

        // zero length behaves as a single data bit
        write_length(6'd0);
        send_request(KIND_ENCODE, '1, '0);
        send_request(KIND_DECODE, '1, '1);
        send_request(KIND_DECODE, '0, CODE_W'(2));

        // oversize length clamps to 57
        write_length(6'd63);
        send_request(KIND_ENCODE, '1, '0);
        word = sb.codec_result(KIND_ENCODE, DATA_W'(rand_word()), '0).code;
        send_request(KIND_DECODE, '0, word ^ (CODE_W'(1) << $urandom_range(62)));

        // random phases, the last three at random lengths, one with no idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase >= RANDOM_PHASES - 3) phase_lengths[phase] = LEN_W'($urandom_range(63));
            write_length(phase_lengths[phase]);
            steady = (phase == 6);
            repeat (REQUESTS_PER_PHASE) random_request();
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.noted != sent || sb.owed_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
